### hdl/fdph_pkg.sv
// Shared types, register indexes and reset values for the position hold block.
`default_nettype none
package fdph_pkg;

  localparam int VEL_W   = 12;
  localparam int DRIVE_W = 9;
  localparam int STEP_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISP_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_GAIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT  = 3'd6;

  localparam logic [15:0] RST_STEP_TIME  = 16'd1311;
  localparam logic [7:0]  RST_DISP_LIMIT = 8'd20;
  localparam logic [7:0]  RST_DEADBAND   = 8'd3;
  localparam logic [9:0]  RST_POS_GAIN   = 10'd154;
  localparam logic [9:0]  RST_VEL_GAIN   = 10'd307;
  localparam logic [8:0]  RST_ALPHA      = 9'd77;
  localparam logic [7:0]  RST_OUT_LIMIT  = 8'd12;

  localparam logic [8:0] ALPHA_ONE = 9'd256;

  // Datapath steps, one multiply issued per step but the last
  typedef logic [2:0] step_t;
  localparam step_t STEP_VST  = 3'd0;  // velocity times step time
  localparam step_t STEP_DISP = 3'd1;  // update displacement, issue damping product
  localparam step_t STEP_DAMP = 3'd2;  // hold damping term, issue restoring product
  localparam step_t STEP_REST = 3'd3;  // form drive, issue old-state product
  localparam step_t STEP_ACC  = 3'd4;  // hold old-state product, issue new-drive product
  localparam step_t STEP_FILT = 3'd5;  // filter sum, clamp, write state and result

  typedef struct packed {
    logic [15:0] step_time;
    logic [7:0]  disp_limit;
    logic [7:0]  deadband;
    logic [9:0]  pos_gain;
    logic [9:0]  vel_gain;
    logic [8:0]  alpha;
    logic [7:0]  out_limit;
  } fdph_cfg_t;

  typedef struct packed {
    logic  load_in;
    logic  step_en;
    step_t step;
    logic  axis;      // 0: X, 1: Y
    logic  load_out;
  } fdph_cmd_t;

endpackage
`default_nettype wire

### hdl/fdph_cfg.sv
// Configuration register file for the position hold block.
`default_nettype none
module fdph_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [fdph_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [fdph_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output fdph_pkg::fdph_cfg_t                   cfg_o
);

  fdph_pkg::fdph_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        fdph_pkg::REG_STEP_TIME:  cfg_d.step_time  = cfg_data_i;
        fdph_pkg::REG_DISP_LIMIT: cfg_d.disp_limit = cfg_data_i[7:0];
        fdph_pkg::REG_DEADBAND:   cfg_d.deadband   = cfg_data_i[7:0];
        fdph_pkg::REG_POS_GAIN:   cfg_d.pos_gain   = cfg_data_i[9:0];
        fdph_pkg::REG_VEL_GAIN:   cfg_d.vel_gain   = cfg_data_i[9:0];
        fdph_pkg::REG_ALPHA:      cfg_d.alpha      = cfg_data_i[8:0];
        fdph_pkg::REG_OUT_LIMIT:  cfg_d.out_limit  = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_time  <= fdph_pkg::RST_STEP_TIME;
      cfg_q.disp_limit <= fdph_pkg::RST_DISP_LIMIT;
      cfg_q.deadband   <= fdph_pkg::RST_DEADBAND;
      cfg_q.pos_gain   <= fdph_pkg::RST_POS_GAIN;
      cfg_q.vel_gain   <= fdph_pkg::RST_VEL_GAIN;
      cfg_q.alpha      <= fdph_pkg::RST_ALPHA;
      cfg_q.out_limit  <= fdph_pkg::RST_OUT_LIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

### hdl/fdph_ctrl.sv
// Sequencer: steps both axes through the shared datapath and owns the handshakes.
`default_nettype none
module fdph_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output fdph_pkg::fdph_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_VST  = 3'd1;
  localparam logic [2:0] S_DISP = 3'd2;
  localparam logic [2:0] S_DAMP = 3'd3;
  localparam logic [2:0] S_REST = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;
  localparam logic [2:0] S_FILT = 3'd6;
  localparam logic [2:0] S_LOAD = 3'd7;

  logic [2:0] state_q, state_d;
  logic       axis_q, axis_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    axis_d        = axis_q;
    cmd_o.load_in = 1'b0;
    cmd_o.step_en = 1'b1;
    cmd_o.step    = fdph_pkg::STEP_VST;
    cmd_o.axis    = axis_q;
    cmd_o.load_out = 1'b0;
    case (state_q)
      S_IDLE: begin
        cmd_o.step_en = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          axis_d  = 1'b0;
          state_d = S_VST;
        end
      end
      S_VST: begin
        cmd_o.step = fdph_pkg::STEP_VST;
        state_d = S_DISP;
      end
      S_DISP: begin
        cmd_o.step = fdph_pkg::STEP_DISP;
        state_d = S_DAMP;
      end
      S_DAMP: begin
        cmd_o.step = fdph_pkg::STEP_DAMP;
        state_d = S_REST;
      end
      S_REST: begin
        cmd_o.step = fdph_pkg::STEP_REST;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.step = fdph_pkg::STEP_ACC;
        state_d = S_FILT;
      end
      S_FILT: begin
        cmd_o.step = fdph_pkg::STEP_FILT;
        if (!axis_q) begin
          axis_d  = 1'b1;
          state_d = S_VST;
        end else begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.step_en = 1'b0;
        // hold the result until the output register is free
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        cmd_o.step_en = 1'b0;
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

### hdl/fdph_dp.sv
// Datapath: per-axis state, one shared signed multiplier, clamps and result registers.
`default_nettype none
module fdph_dp #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire fdph_pkg::fdph_cmd_t                 cmd_i,
  input  wire fdph_pkg::fdph_cfg_t                 cfg_i,
  input  wire logic signed [fdph_pkg::VEL_W-1:0]   velocity_x_i,
  input  wire logic signed [fdph_pkg::VEL_W-1:0]   velocity_y_i,
  output logic signed [fdph_pkg::DRIVE_W-1:0]      drive_x_o,
  output logic signed [fdph_pkg::DRIVE_W-1:0]      drive_y_o
);

  localparam int VW  = fdph_pkg::VEL_W;
  localparam int OW  = fdph_pkg::DRIVE_W;
  localparam int MA  = fdph_pkg::STEP_W + 1;      // gains, alpha, step time
  localparam int MB  = 15 + FRAC_BITS;            // velocity, state, drive
  localparam int PW  = MA + MB;
  localparam int DW  = 9 + FRAC_BITS;             // stored displacement and filter state
  localparam int VST_SHIFT = fdph_pkg::STEP_W - FRAC_BITS;

  localparam logic signed [PW-1:0] ONE_M1 = {{(PW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

  logic signed [VW-1:0] vel_x_q, vel_y_q, vel;
  logic signed [DW-1:0] disp_x_q, disp_y_q, filt_x_q, filt_y_q, disp, filt;
  logic signed [MB-1:0] damp_q, drive_q;
  logic signed [PW-1:0] prod_q, prod_d, acc_q;
  logic signed [OW-1:0] res_x_q, res_y_q;

  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic [8:0]           alpha_sat, alpha_inv;

  logic signed [PW-1:0] disp_ext, disp_sum, disp_new, lim_d, lim_o, db_w, mag;
  logic signed [PW-1:0] damp_w, rest_w, drive_w, damp_ext;
  logic signed [PW-1:0] filt_sum, filt_sh, filt_new, trunc_w;
  logic                 outside;

  assign vel  = cmd_i.axis ? vel_y_q  : vel_x_q;
  assign disp = cmd_i.axis ? disp_y_q : disp_x_q;
  assign filt = cmd_i.axis ? filt_y_q : filt_x_q;

  assign alpha_sat = (cfg_i.alpha > fdph_pkg::ALPHA_ONE) ? fdph_pkg::ALPHA_ONE : cfg_i.alpha;
  assign alpha_inv = fdph_pkg::ALPHA_ONE - alpha_sat;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.step)
      fdph_pkg::STEP_VST: begin
        mul_a = $signed({1'b0, cfg_i.step_time});
        mul_b = {{(MB-VW){vel[VW-1]}}, vel};
      end
      fdph_pkg::STEP_DISP: begin
        mul_a = $signed({{(MA-10){1'b0}}, cfg_i.vel_gain});
        mul_b = {{(MB-VW){vel[VW-1]}}, vel};
      end
      fdph_pkg::STEP_DAMP: begin
        mul_a = $signed({{(MA-10){1'b0}}, cfg_i.pos_gain});
        mul_b = {{(MB-DW){disp[DW-1]}}, disp};
      end
      fdph_pkg::STEP_REST: begin
        mul_a = $signed({{(MA-9){1'b0}}, alpha_inv});
        mul_b = {{(MB-DW){filt[DW-1]}}, filt};
      end
      fdph_pkg::STEP_ACC: begin
        mul_a = $signed({{(MA-9){1'b0}}, alpha_sat});
        mul_b = drive_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // displacement integrate and clamp
  assign disp_ext = {{(PW-DW){disp[DW-1]}}, disp};
  assign lim_d    = $signed({{(PW-8-FRAC_BITS){1'b0}}, cfg_i.disp_limit, {FRAC_BITS{1'b0}}});
  assign lim_o    = $signed({{(PW-8-FRAC_BITS){1'b0}}, cfg_i.out_limit, {FRAC_BITS{1'b0}}});
  assign db_w     = $signed({{(PW-8-FRAC_BITS){1'b0}}, cfg_i.deadband, {FRAC_BITS{1'b0}}});
  assign disp_sum = disp_ext + (prod_q >>> VST_SHIFT);

  always_comb begin
    if (disp_sum > lim_d) begin
      disp_new = lim_d;
    end else if (disp_sum < -lim_d) begin
      disp_new = -lim_d;
    end else begin
      disp_new = disp_sum;
    end
  end

  // damping term: gain times velocity scaled to the state's fraction, floored
  assign damp_w = (prod_q <<< FRAC_BITS) >>> 8;

  // restoring term applies strictly outside the deadband
  assign mag      = disp_ext[PW-1] ? -disp_ext : disp_ext;
  assign outside  = mag > db_w;
  assign rest_w   = (-prod_q) >>> 8;
  assign damp_ext = {{(PW-MB){damp_q[MB-1]}}, damp_q};
  assign drive_w  = (outside ? rest_w : '0) - damp_ext;

  // filter update, clamp and truncation toward zero
  assign filt_sum = acc_q + prod_q;
  assign filt_sh  = filt_sum >>> 8;

  always_comb begin
    if (filt_sh > lim_o) begin
      filt_new = lim_o;
    end else if (filt_sh < -lim_o) begin
      filt_new = -lim_o;
    end else begin
      filt_new = filt_sh;
    end
  end

  assign trunc_w = (filt_new + (filt_new[PW-1] ? ONE_M1 : '0)) >>> FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_x_q <= '0;
      disp_y_q <= '0;
      filt_x_q <= '0;
      filt_y_q <= '0;
    end else if (cmd_i.step_en) begin
      if (cmd_i.step == fdph_pkg::STEP_DISP) begin
        if (cmd_i.axis) begin
          disp_y_q <= disp_new[DW-1:0];
        end else begin
          disp_x_q <= disp_new[DW-1:0];
        end
      end
      if (cmd_i.step == fdph_pkg::STEP_FILT) begin
        if (cmd_i.axis) begin
          filt_y_q <= filt_new[DW-1:0];
        end else begin
          filt_x_q <= filt_new[DW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      vel_x_q <= velocity_x_i;
      vel_y_q <= velocity_y_i;
    end
    if (cmd_i.step_en) begin
      prod_q <= prod_d;
      case (cmd_i.step)
        fdph_pkg::STEP_DAMP: damp_q  <= damp_w[MB-1:0];
        fdph_pkg::STEP_REST: drive_q <= drive_w[MB-1:0];
        fdph_pkg::STEP_ACC:  acc_q   <= prod_q;
        fdph_pkg::STEP_FILT: begin
          if (cmd_i.axis) begin
            res_y_q <= trunc_w[OW-1:0];
          end else begin
            res_x_q <= trunc_w[OW-1:0];
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.load_out) begin
      drive_x_o <= res_x_q;
      drive_y_o <= res_y_q;
    end
  end

endmodule
`default_nettype wire

### hdl/flow_damping_position_hold_top.sv
// Top level of the two-axis flow damping position hold.
// Each accepted tick runs the X axis and then the Y axis through one shared
// 17 by (15 + FRAC_BITS) bit signed multiplier in the VST, DISP, DAMP, REST,
// ACC and FILT steps, and a load step then moves both drives into the output
// register; the block takes no new tick until that load is done. A result
// left waiting in the output register stalls the block only when the next one
// is finished. Displacement and filter state are cleared by reset;
// configuration writes take effect at once and belong between ticks.
`default_nettype none
module flow_damping_position_hold_top #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [fdph_pkg::VEL_W-1:0]   velocity_x_i,
  input  wire logic signed [fdph_pkg::VEL_W-1:0]   velocity_y_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [fdph_pkg::DRIVE_W-1:0]      drive_x_o,
  output logic signed [fdph_pkg::DRIVE_W-1:0]      drive_y_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [fdph_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [fdph_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  fdph_pkg::fdph_cfg_t cfg;
  fdph_pkg::fdph_cmd_t cmd;

  fdph_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fdph_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  fdph_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_i        (cfg),
    .velocity_x_i (velocity_x_i),
    .velocity_y_i (velocity_y_i),
    .drive_x_o    (drive_x_o),
    .drive_y_o    (drive_y_o)
  );

endmodule
`default_nettype wire

### hdl/fdph_checker.sv
// Port-level checks for the position hold top level, bound to it.
`default_nettype none
module fdph_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_valid_i,
  input wire logic                               in_ready_o,
  input wire logic                               out_valid_o,
  input wire logic                               out_ready_i,
  input wire logic [fdph_pkg::DRIVE_W-1:0]       drive_x_o,
  input wire logic [fdph_pkg::DRIVE_W-1:0]       drive_y_o
);

  localparam logic [fdph_pkg::DRIVE_W-1:0] DRIVE_MIN_CODE = 9'h100;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(drive_x_o) && $stable(drive_y_o))
    else $error("stalled result changed");

  // an input transfer starts a multi-cycle computation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // a new result appears only after a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without computation");

  // clamped drives never reach the most negative code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> drive_x_o != DRIVE_MIN_CODE && drive_y_o != DRIVE_MIN_CODE)
    else $error("drive outside clamp range");

endmodule

bind flow_damping_position_hold_top fdph_checker u_fdph_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .drive_x_o   (drive_x_o),
  .drive_y_o   (drive_y_o)
);
`default_nettype wire

### tb/flow_damping_position_hold_top_test.sv
// Self-checking testbench for the two-axis flow damping position hold block.
module flow_damping_position_hold_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS   = 8;
  localparam int STATE_W     = 24;
  localparam int PHASES      = 12;
  localparam int PHASE_TICKS = 75;

  typedef enum int {RX_STEADY, RX_CHOPPY, RX_BLOCKY} rx_mode_e;

  typedef logic [fdph_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [fdph_pkg::CFG_DATA_W-1:0] cfg_data_t;

  typedef struct packed {
    logic signed [fdph_pkg::DRIVE_W-1:0] drive_x;
    logic signed [fdph_pkg::DRIVE_W-1:0] drive_y;
  } drive_pair_t;

  // Tracks the hold state per axis and holds the drives still owed by the block.
  class hold_scoreboard;
    fdph_pkg::fdph_cfg_t       regs;
    logic signed [STATE_W-1:0] disp_x, disp_y, filt_x, filt_y;
    drive_pair_t               expected_drives[$];
    int unsigned               errors;

    function new();
      regs.step_time  = fdph_pkg::RST_STEP_TIME;
      regs.disp_limit = fdph_pkg::RST_DISP_LIMIT;
      regs.deadband   = fdph_pkg::RST_DEADBAND;
      regs.pos_gain   = fdph_pkg::RST_POS_GAIN;
      regs.vel_gain   = fdph_pkg::RST_VEL_GAIN;
      regs.alpha      = fdph_pkg::RST_ALPHA;
      regs.out_limit  = fdph_pkg::RST_OUT_LIMIT;
      disp_x = '0;
      disp_y = '0;
      filt_x = '0;
      filt_y = '0;
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, cfg_data_t data);
      case (idx)
        fdph_pkg::REG_STEP_TIME:  regs.step_time  = data[15:0];
        fdph_pkg::REG_DISP_LIMIT: regs.disp_limit = data[7:0];
        fdph_pkg::REG_DEADBAND:   regs.deadband   = data[7:0];
        fdph_pkg::REG_POS_GAIN:   regs.pos_gain   = data[9:0];
        fdph_pkg::REG_VEL_GAIN:   regs.vel_gain   = data[9:0];
        fdph_pkg::REG_ALPHA:      regs.alpha      = data[8:0];
        fdph_pkg::REG_OUT_LIMIT:  regs.out_limit  = data[7:0];
        default: ;
      endcase
    endfunction

    // One axis of one tick; shifts on signed values floor toward minus infinity.
    function logic signed [fdph_pkg::DRIVE_W-1:0] advance_axis(
        input logic signed [fdph_pkg::VEL_W-1:0] vel,
        inout logic signed [STATE_W-1:0]         disp,
        inout logic signed [STATE_W-1:0]         filt);
      longint v, d, f, one, lim, mag, drive, alpha, q;
      v     = vel;
      d     = disp;
      f     = filt;
      one   = longint'(1) <<< FRAC_BITS;
      alpha = (regs.alpha > fdph_pkg::ALPHA_ONE) ? 256 : longint'(regs.alpha);
      drive = 0;

      d   = d + ((v * longint'(regs.step_time)) >>> (16 - FRAC_BITS));
      lim = longint'(regs.disp_limit) * one;
      if (d > lim) d = lim;
      else if (d < -lim) d = -lim;

      mag = (d < 0) ? -d : d;
      if (mag > longint'(regs.deadband) * one)
        drive = (-(longint'(regs.pos_gain) * d)) >>> 8;
      drive = drive - ((longint'(regs.vel_gain) * v * one) >>> 8);

      f   = (alpha * drive + (256 - alpha) * f) >>> 8;
      lim = longint'(regs.out_limit) * one;
      if (f > lim) f = lim;
      else if (f < -lim) f = -lim;

      // truncate toward zero for the command
      q    = f / one;
      disp = d[STATE_W-1:0];
      filt = f[STATE_W-1:0];
      return q[fdph_pkg::DRIVE_W-1:0];
    endfunction

    function void log_tick(logic signed [fdph_pkg::VEL_W-1:0] vx,
                           logic signed [fdph_pkg::VEL_W-1:0] vy);
      drive_pair_t pair;
      pair.drive_x = advance_axis(vx, disp_x, filt_x);
      pair.drive_y = advance_axis(vy, disp_y, filt_y);
      expected_drives.push_back(pair);
    endfunction

    function void check_drive(logic signed [fdph_pkg::DRIVE_W-1:0] dx,
                              logic signed [fdph_pkg::DRIVE_W-1:0] dy);
      drive_pair_t want;
      if (expected_drives.size() == 0) begin
        $error("drive result with no tick pending: drive_x %0d, drive_y %0d", dx, dy);
        errors++;
      end else begin
        want = expected_drives.pop_front();
        if (dx !== want.drive_x) begin
          $error("drive_x: expected %0d, actual %0d", want.drive_x, dx);
          errors++;
        end
        if (dy !== want.drive_y) begin
          $error("drive_y: expected %0d, actual %0d", want.drive_y, dy);
          errors++;
        end
      end
    endfunction
  endclass

  logic                                clk_i        = 1'b0;
  logic                                rst_ni       = 1'b0;
  logic                                in_valid_i   = 1'b0;
  logic                                in_ready_o;
  logic signed [fdph_pkg::VEL_W-1:0]   velocity_x_i = '0;
  logic signed [fdph_pkg::VEL_W-1:0]   velocity_y_i = '0;
  logic                                out_valid_o;
  logic                                out_ready_i  = 1'b0;
  logic signed [fdph_pkg::DRIVE_W-1:0] drive_x_o;
  logic signed [fdph_pkg::DRIVE_W-1:0] drive_y_o;
  logic                                cfg_we_i     = 1'b0;
  cfg_idx_t                            cfg_index_i  = '0;
  cfg_data_t                           cfg_data_i   = '0;

  hold_scoreboard              board;
  cfg_data_t                   reg_plan [7];
  rx_mode_e                    rx_mode    = RX_STEADY;
  int unsigned                 stall_left = 0;

  flow_damping_position_hold_top #(
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .velocity_x_i(velocity_x_i),
    .velocity_y_i(velocity_y_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .drive_x_o   (drive_x_o),
    .drive_y_o   (drive_y_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) board.log_tick(velocity_x_i, velocity_y_i);
    if (rst_ni && out_valid_o && out_ready_i) board.check_drive(drive_x_o, drive_y_o);
  end

  // Output side back-pressure
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      case (rx_mode)
        RX_STEADY: out_ready_i <= 1'b1;
        RX_CHOPPY: out_ready_i <= ($urandom_range(0, 3) != 0);
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            out_ready_i <= 1'b0;
            stall_left  <= $urandom_range(1, 30);
          end else begin
            out_ready_i <= 1'b1;
          end
        end
      endcase
    end
  end

  initial begin
    #(5_000_000);
    $display("FAILURE");
    $finish;
  end

  // Present one tick and hold it until the transfer.
  task automatic send_tick(logic signed [fdph_pkg::VEL_W-1:0] vx,
                           logic signed [fdph_pkg::VEL_W-1:0] vy);
    in_valid_i   <= 1'b1;
    velocity_x_i <= vx;
    velocity_y_i <= vy;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    // let the last transfer reach the scoreboard first
    @(posedge clk_i);
    while (board.expected_drives.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_regs();
    for (int i = 0; i < 7; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= cfg_idx_t'(i);
      cfg_data_i  <= reg_plan[i];
      board.write_reg(cfg_idx_t'(i), reg_plan[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [fdph_pkg::VEL_W-1:0] pick_velocity();
    int unsigned r;
    int          v;
    r = $urandom_range(0, 99);
    if (r < 45) v = int'($urandom_range(0, 40)) - 20;
    else if (r < 70) v = int'($urandom_range(0, 600)) - 300;
    else if (r < 90) v = int'($urandom_range(0, 4095)) - 2048;
    else begin
      case ($urandom_range(0, 3))
        0: v = 2047;
        1: v = -2048;
        2: v = 0;
        default: v = -1;
      endcase
    end
    return v[fdph_pkg::VEL_W-1:0];
  endfunction

  // Bursts of ticks with random gaps; optionally drain once halfway through.
  task automatic run_phase(int unsigned count, int unsigned max_gap, bit pause_mid);
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    bit          paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        if (sent < count) begin
          send_tick(pick_velocity(), pick_velocity());
          sent++;
        end
      end
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if (pause_mid && !paused && sent >= count / 2) begin
        wait_drained();
        paused = 1'b1;
      end else if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    wait_drained();
  endtask

  initial begin
    board = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values written back explicitly, then field extremes
    reg_plan[fdph_pkg::REG_STEP_TIME]  = cfg_data_t'(fdph_pkg::RST_STEP_TIME);
    reg_plan[fdph_pkg::REG_DISP_LIMIT] = cfg_data_t'(fdph_pkg::RST_DISP_LIMIT);
    reg_plan[fdph_pkg::REG_DEADBAND]   = cfg_data_t'(fdph_pkg::RST_DEADBAND);
    reg_plan[fdph_pkg::REG_POS_GAIN]   = cfg_data_t'(fdph_pkg::RST_POS_GAIN);
    reg_plan[fdph_pkg::REG_VEL_GAIN]   = cfg_data_t'(fdph_pkg::RST_VEL_GAIN);
    reg_plan[fdph_pkg::REG_ALPHA]      = cfg_data_t'(fdph_pkg::RST_ALPHA);
    reg_plan[fdph_pkg::REG_OUT_LIMIT]  = cfg_data_t'(fdph_pkg::RST_OUT_LIMIT);
    write_regs();
    send_tick(12'sd0, 12'sd0);
    send_tick(12'sd2047, -12'sd2048);
    send_tick(-12'sd2048, 12'sd2047);
    send_tick(12'sd1, -12'sd1);
    send_tick(-12'sd1, 12'sd1);
    send_tick(12'sd2047, 12'sd2047);
    send_tick(-12'sd2048, -12'sd2048);
    send_tick(12'sd20, -12'sd20);
    send_tick(12'sd5, -12'sd5);
    send_tick(12'sd0, 12'sd0);
    send_tick(12'sd0, 12'sd0);
    send_tick(12'sd0, 12'sd0);
    wait_drained();

    // Alpha above one, zero step time, zero displacement limit
    reg_plan[fdph_pkg::REG_STEP_TIME]  = 16'd0;
    reg_plan[fdph_pkg::REG_DISP_LIMIT] = 16'd0;
    reg_plan[fdph_pkg::REG_ALPHA]      = 16'd300;
    write_regs();
    send_tick(12'sd10, -12'sd10);
    send_tick(12'sd100, -12'sd100);
    send_tick(12'sd2047, -12'sd2048);
    send_tick(12'sd0, 12'sd0);
    send_tick(-12'sd7, 12'sd7);
    send_tick(12'sd3, 12'sd3);
    wait_drained();

    // Largest step and gains, no deadband, zero output limit
    reg_plan[fdph_pkg::REG_STEP_TIME]  = 16'hFFFF;
    reg_plan[fdph_pkg::REG_DISP_LIMIT] = 16'd255;
    reg_plan[fdph_pkg::REG_DEADBAND]   = 16'd0;
    reg_plan[fdph_pkg::REG_POS_GAIN]   = 16'd1023;
    reg_plan[fdph_pkg::REG_VEL_GAIN]   = 16'd1023;
    reg_plan[fdph_pkg::REG_ALPHA]      = cfg_data_t'(fdph_pkg::ALPHA_ONE);
    reg_plan[fdph_pkg::REG_OUT_LIMIT]  = 16'd0;
    write_regs();
    send_tick(12'sd2047, -12'sd2048);
    send_tick(12'sd2047, -12'sd2048);
    send_tick(-12'sd1, 12'sd1);
    send_tick(12'sd0, 12'sd0);
    send_tick(-12'sd2048, 12'sd2047);
    send_tick(12'sd15, -12'sd15);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        reg_plan[fdph_pkg::REG_STEP_TIME]  = cfg_data_t'(fdph_pkg::RST_STEP_TIME);
        reg_plan[fdph_pkg::REG_DISP_LIMIT] = cfg_data_t'(fdph_pkg::RST_DISP_LIMIT);
        reg_plan[fdph_pkg::REG_DEADBAND]   = cfg_data_t'(fdph_pkg::RST_DEADBAND);
        reg_plan[fdph_pkg::REG_POS_GAIN]   = cfg_data_t'(fdph_pkg::RST_POS_GAIN);
        reg_plan[fdph_pkg::REG_VEL_GAIN]   = cfg_data_t'(fdph_pkg::RST_VEL_GAIN);
        reg_plan[fdph_pkg::REG_ALPHA]      = cfg_data_t'(fdph_pkg::RST_ALPHA);
        reg_plan[fdph_pkg::REG_OUT_LIMIT]  = cfg_data_t'(fdph_pkg::RST_OUT_LIMIT);
      end else if (ph == 3) begin
        reg_plan[fdph_pkg::REG_STEP_TIME]  = 16'hFFFF;
        reg_plan[fdph_pkg::REG_DISP_LIMIT] = 16'h00FF;
        reg_plan[fdph_pkg::REG_DEADBAND]   = 16'h00FF;
        reg_plan[fdph_pkg::REG_POS_GAIN]   = 16'h03FF;
        reg_plan[fdph_pkg::REG_VEL_GAIN]   = 16'h03FF;
        reg_plan[fdph_pkg::REG_ALPHA]      = 16'h01FF;
        reg_plan[fdph_pkg::REG_OUT_LIMIT]  = 16'h00FF;
      end else if (ph == 6) begin
        foreach (reg_plan[i]) reg_plan[i] = '0;
      end else if (ph % 2 == 1) begin
        // anything the register widths allow
        reg_plan[fdph_pkg::REG_STEP_TIME]  = 16'($urandom & 32'hFFFF);
        reg_plan[fdph_pkg::REG_DISP_LIMIT] = 16'($urandom & 32'hFF);
        reg_plan[fdph_pkg::REG_DEADBAND]   = 16'($urandom & 32'hFF);
        reg_plan[fdph_pkg::REG_POS_GAIN]   = 16'($urandom & 32'h3FF);
        reg_plan[fdph_pkg::REG_VEL_GAIN]   = 16'($urandom & 32'h3FF);
        reg_plan[fdph_pkg::REG_ALPHA]      = 16'($urandom & 32'h1FF);
        reg_plan[fdph_pkg::REG_OUT_LIMIT]  = 16'($urandom & 32'hFF);
      end else begin
        // settings near a usable hold, so deadband and clamps both come into play
        reg_plan[fdph_pkg::REG_STEP_TIME]  = 16'($urandom_range(200, 4000));
        reg_plan[fdph_pkg::REG_DISP_LIMIT] = 16'($urandom_range(1, 60));
        reg_plan[fdph_pkg::REG_DEADBAND]   = 16'($urandom_range(0, 10));
        reg_plan[fdph_pkg::REG_POS_GAIN]   = 16'($urandom_range(0, 600));
        reg_plan[fdph_pkg::REG_VEL_GAIN]   = 16'($urandom_range(0, 600));
        reg_plan[fdph_pkg::REG_ALPHA]      = 16'($urandom_range(0, 300));
        reg_plan[fdph_pkg::REG_OUT_LIMIT]  = 16'($urandom_range(1, 200));
      end
      write_regs();
      rx_mode = (ph == 4) ? RX_STEADY : rx_mode_e'(ph % 3);
      run_phase(PHASE_TICKS, (ph == 4) ? 0 : ((ph % 3 == 0) ? 3 : 20), (ph % 2 == 0));
    end

    if (board.expected_drives.size() != 0) begin
      $error("drive results missing: %0d ticks outstanding", board.expected_drives.size());
    end
    if (board.errors == 0 && board.expected_drives.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

### filelist.f
hdl/fdph_pkg.sv
hdl/fdph_cfg.sv
hdl/fdph_ctrl.sv
hdl/fdph_dp.sv
hdl/flow_damping_position_hold_top.sv
hdl/fdph_checker.sv
tb/flow_damping_position_hold_top_test.sv
